// ----- rtl/core/urt_pkg.sv -----
// Shared types and constants for the UART register block with text terminal.
// No dependencies; every other file of the block imports this package.
package urt_pkg;

  // Receive FIFO geometry.
  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned FIFO_AW    = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Terminal geometry.
  localparam int unsigned TERM_COLS = 80;
  localparam int unsigned TERM_ROWS = 25;
  localparam int unsigned COL_W     = $clog2(TERM_COLS + 1);
  localparam int unsigned ROW_W     = $clog2(TERM_ROWS + 1);

  // Field widths of the stream items.
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned OFFSET_W  = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RDATA_W   = 16;
  localparam int unsigned OUT_ROW_W = 5;
  localparam int unsigned OUT_COL_W = 7;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;

  // Item kinds.
  localparam logic [ACTION_W-1:0] ACT_KEY   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

  // Register offsets.
  localparam logic [OFFSET_W-1:0] OFF_DATA   = 4'h0;
  localparam logic [OFFSET_W-1:0] OFF_STATUS = 4'h6;
  localparam logic [OFFSET_W-1:0] OFF_LSR    = 4'hC;

  // Read values of the status registers.
  localparam logic [RDATA_W-1:0] STATUS_READY = 16'hFFFF;
  localparam logic [RDATA_W-1:0] STATUS_IDLE  = 16'h0000;
  localparam logic [RDATA_W-1:0] LSR_READY    = 16'h0C07;
  localparam logic [RDATA_W-1:0] LSR_IDLE     = 16'h0C03;

  // Control characters.
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic waiting;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             scrolled;
  } term_res_t;

endpackage

// ----- rtl/core/uart_regs_with_text_terminal.sv -----
// UART register block: receive FIFO, bus registers and terminal cursor tracking.
// An accepted item passes through stage one and then the result register before it
// is offered. Throughput: one item per cycle while the output is not stalled; the result
// stage and a holding stage in front of it let one more item in while a result
// waits. Reset (rst_ni low, asynchronous) empties the FIFO, homes the cursor and
// drops both pipeline stages. Depends on urt_pkg, urt_rx_fifo and urt_term.
module uart_regs_with_text_terminal (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input item stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, low bit up: offset[3:0], data[11:4], zero fill [15:12].
  input  logic [urt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action[1:0] (key byte, bus read or bus write).
  input  logic [urt_pkg::ACTION_W-1:0]   s_axis_tuser,
  // Result item stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, low bit up: read_data[15:0], tx_valid[16], tx_byte[24:17],
  // cursor_row[29:25], cursor_col[36:30], scrolled[37], rx_overflow[38],
  // zero fill [39].
  output logic [urt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import urt_pkg::*;

  // Input decode. All state (FIFO pointers, cursor) updates at the edge that
  // accepts the item, so the next item sees the updated state.
  logic                accept;
  logic [OFFSET_W-1:0] in_offset;
  logic [BYTE_W-1:0]   in_data;
  logic                is_key, is_read, is_tx;
  fifo_ctrl_t          fifo_ctrl;
  fifo_stat_t          fifo_stat;
  logic [BYTE_W-1:0]   fifo_rdata;
  term_res_t           term_res;
  logic [RDATA_W-1:0]  reg_rdata;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_offset = s_axis_tdata[OFFSET_W-1:0];
  assign in_data   = s_axis_tdata[OFFSET_W +: BYTE_W];
  assign is_key    = accept && (s_axis_tuser == ACT_KEY);
  assign is_read   = accept && (s_axis_tuser == ACT_READ);
  assign is_tx     = accept && (s_axis_tuser == ACT_WRITE) && (in_offset == OFF_DATA);

  assign fifo_ctrl.push = is_key;
  assign fifo_ctrl.pop  = is_read && (in_offset == OFF_DATA);

  urt_rx_fifo u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .data_i  (in_data),
    .stat_o  (fifo_stat),
    .rdata_o (fifo_rdata)
  );

  urt_term u_term (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .put_i  (is_tx),
    .char_i (in_data),
    .res_o  (term_res)
  );

  // Status registers read from the fill state before this item's update.
  always_comb begin
    reg_rdata = '0;
    unique case (in_offset)
      OFF_STATUS: reg_rdata = fifo_stat.waiting ? STATUS_READY : STATUS_IDLE;
      OFF_LSR:    reg_rdata = fifo_stat.waiting ? LSR_READY : LSR_IDLE;
      default:    reg_rdata = '0;
    endcase
  end

  // Stage one holds the decoded result; the popped byte arrives from the
  // FIFO's read register at the same edge.
  logic                 s1_valid_q;
  logic                 s1_pop_q;
  logic [RDATA_W-1:0]   s1_rdata_q;
  logic                 s1_tx_q;
  logic [BYTE_W-1:0]    s1_byte_q;
  logic [OUT_ROW_W-1:0] s1_row_q;
  logic [OUT_COL_W-1:0] s1_col_q;
  logic                 s1_scroll_q;
  logic                 s1_ovf_q;
  logic                 s1_advance;

  // Stage two is the result register on the output port.
  logic                  s2_valid_q;
  logic [OUT_DATA_W-1:0] s2_data_q;
  logic [OUT_DATA_W-1:0] s2_data_d;

  assign s1_advance    = s1_valid_q && (!s2_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        s2_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pop_q    <= fifo_ctrl.pop && fifo_stat.waiting;
      s1_rdata_q  <= is_read ? reg_rdata : '0;
      s1_tx_q     <= is_tx;
      s1_byte_q   <= is_tx ? in_data : '0;
      s1_row_q    <= OUT_ROW_W'(term_res.row);
      s1_col_q    <= OUT_COL_W'(term_res.col);
      s1_scroll_q <= term_res.scrolled;
      s1_ovf_q    <= is_key && fifo_stat.full;
    end
    if (s1_advance) begin
      s2_data_q <= s2_data_d;
    end
  end

  always_comb begin
    s2_data_d = '0;
    s2_data_d[RDATA_W-1:0] = s1_pop_q ? RDATA_W'(fifo_rdata) : s1_rdata_q;
    s2_data_d[16]          = s1_tx_q;
    s2_data_d[24:17]       = s1_byte_q;
    s2_data_d[29:25]       = s1_row_q;
    s2_data_d[36:30]       = s1_col_q;
    s2_data_d[37]          = s1_scroll_q;
    s2_data_d[38]          = s1_ovf_q;
  end

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = s2_data_q;

  // A stalled result stage keeps the held item waiting in stage one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && !m_axis_tready) |=> s1_valid_q)
    else $error("stage one item lost under backpressure");

  // No input is taken while stage one is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_advance) |-> !s_axis_tready)
    else $error("input taken while stage one blocked");

  // A transmitted byte and a read value never share one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(s1_tx_q && (s1_pop_q || (s1_rdata_q != '0))))
    else $error("result mixes transmit and read");

endmodule

// ----- rtl/core/urt_rx_fifo.sv -----
// Receive FIFO of key bytes with a registered read port.
// Depends on urt_pkg.
module urt_rx_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urt_pkg::fifo_ctrl_t           ctrl_i,
  input  logic [urt_pkg::BYTE_W-1:0]    data_i,
  output urt_pkg::fifo_stat_t           stat_o,
  output logic [urt_pkg::BYTE_W-1:0]    rdata_o
);
  import urt_pkg::*;

  logic [BYTE_W-1:0]  mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic [BYTE_W-1:0]  rdata_q;
  logic               do_push, do_pop;

  assign stat_o.waiting = (count_q != '0);
  assign stat_o.full    = (count_q == FIFO_CW'(FIFO_DEPTH));

  // A push into a full FIFO is dropped, a pop from an empty one does nothing.
  assign do_push = ctrl_i.push && !stat_o.full;
  assign do_pop  = ctrl_i.pop && stat_o.waiting;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      count_d  = count_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
    if (do_pop) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign rdata_o = rdata_q;

  // The fill level never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("rx fifo count above depth");

  // A push alone raises the fill level by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("rx fifo count did not follow a push");

  // A pop alone lowers the fill level by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("rx fifo count did not follow a pop");

endmodule

// ----- rtl/core/urt_term.sv -----
// Cursor tracking of the character terminal: line feed, wrap and scroll.
// Depends on urt_pkg.
module urt_term (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       put_i,
  input  logic [urt_pkg::BYTE_W-1:0] char_i,
  output urt_pkg::term_res_t         res_o
);
  import urt_pkg::*;

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_step;
  logic [COL_W-1:0] col_step;
  logic             scrolled;

  always_comb begin
    row_step = row_q;
    col_step = col_q;
    scrolled = 1'b0;
    if (put_i) begin
      if (char_i == CHAR_LF) begin
        col_step = '0;
        row_step = row_q + 1'b1;
      end else if (char_i != CHAR_CR) begin
        col_step = col_q + 1'b1;
      end
      // A full row wraps to the start of the next one.
      if (col_step >= COL_W'(TERM_COLS)) begin
        col_step = '0;
        row_step = row_q + 1'b1;
      end
    end
    row_d = row_step;
    col_d = col_step;
    // Past the bottom line the screen moves up and the cursor stays on it.
    if (row_step >= ROW_W'(TERM_ROWS)) begin
      row_d    = ROW_W'(TERM_ROWS - 1);
      scrolled = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign res_o.row      = row_d;
  assign res_o.col      = col_d;
  assign res_o.scrolled = scrolled;

  // The cursor always stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < ROW_W'(TERM_ROWS)) && (col_q < COL_W'(TERM_COLS)))
    else $error("terminal cursor off screen");

  // A scroll leaves the cursor on the bottom line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scrolled |=> (row_q == ROW_W'(TERM_ROWS - 1)))
    else $error("terminal scroll left cursor off bottom line");

  // Without a character the cursor does not move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !put_i |=> ($stable(row_q) && $stable(col_q)))
    else $error("terminal cursor moved without a character");

endmodule
